// ----- design/bpu_pkg.sv -----
package bpu_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;

    // register indexes of the configuration port
    localparam logic [2:0] REG_BPP    = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_RMASK  = 3'd3;
    localparam logic [2:0] REG_GMASK  = 3'd4;
    localparam logic [2:0] REG_BMASK  = 3'd5;
    localparam logic [2:0] REG_AMASK  = 3'd6;

    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [7:0] FULL_CHAN = 8'd255;

    typedef struct packed {
        logic in_ready;
        logic pal_wr;
        logic take;
        logic fin;
        logic div_load;
        logic rgb_load;
        logic pal_rd;
        logic pal_load;
        logic div_step;
        logic bf_load;
        logic pix_adv;
        logic out_valid;
    } t_cmd;

    typedef struct packed {
        logic bpp_ok;
        logic pal_mode;
        logic bf_mode;
        logic pix_emit;
        logic col_lt_w;
        logic out_last;
    } t_status;

endpackage

// ----- design/bpu_in_if.sv -----
interface bpu_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;

    modport source (output valid, op, data_byte, palette_index, palette_color, input ready);
    modport sink   (input valid, op, data_byte, palette_index, palette_color, output ready);
endinterface

// ----- design/bpu_out_if.sv -----
interface bpu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last;

    modport source (output valid, red, green, blue, alpha, pixel_x, pixel_y, last,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, pixel_x, pixel_y, last,
                    output ready);
endinterface

// ----- design/bpu_cfg_if.sv -----
interface bpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bpu_ram.sv -----
module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bpu_datapath.sv -----
module bpu_datapath #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpu_pkg::t_cmd    i_cmd,
    output bpu_pkg::t_status o_status,
    input  logic [7:0]       i_data_byte,
    input  logic [7:0]       i_palette_index,
    input  logic [23:0]      i_palette_color,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [11:0]      o_pixel_x,
    output logic [11:0]      o_pixel_y,
    output logic             o_last
);
    import bpu_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int BIR_W  = $clog2(4 * MAX_WIDTH + 1);
    localparam int PAD_W  = COL_W + 3;

    // configuration
    logic [5:0]  r_bpp;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [31:0] r_mask [4];

    // position and gathering state
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [BIR_W-1:0] r_bir, n_bir;
    logic [1:0]       r_bip, n_bip;
    logic [31:0]      r_acc, n_acc;
    logic [2:0]       r_j, n_j;
    logic [PALETTE_DEPTH-1:0] r_pal_vld;

    // payload
    logic [7:0]       r_sh;
    logic [ROW_W-1:0] r_y;
    logic             r_rd_ok;
    logic [31:0]      r_rem [4];
    logic [7:0]       r_q [4];
    logic [7:0]       r_red, r_green, r_blue, r_alpha;
    logic [COL_W-1:0] r_x;
    logic             r_last;

    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W-1:0] row_w;
    logic             bpp_ok, pal_mode, bf_mode;
    logic [2:0]       need;
    logic [1:0]       bip_inc;
    logic             complete;
    logic [31:0]      acc_or;
    logic [PAD_W-1:0] rb, pad;
    logic [7:0]       pi;
    logic [2:0]       per_m1;
    logic [7:0]       sh_next;
    logic             pi_in_range;
    logic             pal_wr_ok;
    logic [23:0]      ram_rdata;
    logic [31:0]      ext_w, ext_h;

    always_comb begin
        ext_w = 32'(r_width);
        ext_h = 32'(r_height);
        if (ext_w == 32'd0) begin
            w_eff = COL_W'(1);
        end else if (ext_w > 32'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(ext_w);
        end
        if (ext_h == 32'd0) begin
            h_eff = ROW_W'(1);
        end else if (ext_h > 32'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(ext_h);
        end
    end

    always_comb begin
        bpp_ok   = 1'b1;
        pal_mode = 1'b0;
        bf_mode  = 1'b0;
        pi       = r_sh;
        per_m1   = 3'd0;
        sh_next  = 8'd0;
        rb       = PAD_W'(w_eff);
        case (r_bpp)
            6'd1: begin
                pal_mode = 1'b1;
                pi       = {7'd0, r_sh[7]};
                per_m1   = 3'd7;
                sh_next  = {r_sh[6:0], 1'b0};
                rb       = (PAD_W'(w_eff) + PAD_W'(7)) >> 3;
            end
            6'd2: begin
                pal_mode = 1'b1;
                pi       = {6'd0, r_sh[7:6]};
                per_m1   = 3'd3;
                sh_next  = {r_sh[5:0], 2'b0};
                rb       = ((PAD_W'(w_eff) << 1) + PAD_W'(7)) >> 3;
            end
            6'd4: begin
                pal_mode = 1'b1;
                pi       = {4'd0, r_sh[7:4]};
                per_m1   = 3'd1;
                sh_next  = {r_sh[3:0], 4'b0};
                rb       = ((PAD_W'(w_eff) << 2) + PAD_W'(7)) >> 3;
            end
            6'd8: begin
                pal_mode = 1'b1;
                rb       = PAD_W'(w_eff);
            end
            6'd16: begin
                bf_mode = 1'b1;
                rb      = PAD_W'(w_eff) << 1;
            end
            6'd24: begin
                rb = PAD_W'(w_eff) + (PAD_W'(w_eff) << 1);
            end
            6'd32: begin
                bf_mode = 1'b1;
                rb      = PAD_W'(w_eff) << 2;
            end
            default: begin
                bpp_ok = 1'b0;
            end
        endcase
        pad = (rb + PAD_W'(3)) & ~PAD_W'(3);
    end

    assign need     = r_bpp[5:3];
    assign bip_inc  = r_bip + 2'd1;
    assign complete = ({1'b0, bip_inc} >= need) || (bip_inc == 2'd0);
    assign acc_or   = r_acc | (32'(i_data_byte) << {r_bip, 3'b000});
    assign row_w    = (r_row >= h_eff) ? '0 : r_row;

    assign o_status.bpp_ok   = bpp_ok;
    assign o_status.pal_mode = pal_mode;
    assign o_status.bf_mode  = bf_mode;
    assign o_status.col_lt_w = r_col < w_eff;
    assign o_status.pix_emit = complete && (r_col < w_eff);
    assign o_status.out_last = r_last;

    always_comb begin
        logic [ROW_W-1:0] row_base;
        logic [ROW_W-1:0] row_inc;
        logic [BIR_W-1:0] bir_inc;
        n_row = r_row;
        n_col = r_col;
        n_bir = r_bir;
        n_bip = r_bip;
        n_acc = r_acc;
        n_j   = r_j;
        row_base = r_row;
        if (i_cmd.take) begin
            row_base = row_w;
            n_row    = row_w;
            n_j      = 3'd0;
            if (!pal_mode) begin
                if (complete) begin
                    n_acc = '0;
                    n_bip = '0;
                end else begin
                    n_acc = acc_or;
                    n_bip = bip_inc;
                end
            end
        end
        if (i_cmd.pix_adv) begin
            n_col = r_col + COL_W'(1);
            n_j   = r_j + 3'd1;
        end
        row_inc = row_base + ROW_W'(1);
        bir_inc = r_bir + BIR_W'(1);
        if (i_cmd.fin) begin
            if (PAD_W'(bir_inc) >= pad) begin
                n_bir = '0;
                n_col = '0;
                n_bip = '0;
                n_acc = '0;
                n_row = (row_inc >= h_eff) ? '0 : row_inc;
            end else begin
                n_bir = bir_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp     <= 6'd24;
            r_width   <= 13'd1;
            r_height  <= 13'd1;
            r_mask[0] <= '0;
            r_mask[1] <= '0;
            r_mask[2] <= '0;
            r_mask[3] <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_bir     <= '0;
            r_bip     <= '0;
            r_acc     <= '0;
            r_j       <= '0;
            r_pal_vld <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_bir <= n_bir;
            r_bip <= n_bip;
            r_acc <= n_acc;
            r_j   <= n_j;
            if (i_cmd.pal_wr && pal_wr_ok) begin
                r_pal_vld[i_palette_index[ADDR_W-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BPP:    r_bpp     <= i_cfg_data[5:0];
                    REG_WIDTH:  r_width   <= i_cfg_data[12:0];
                    REG_HEIGHT: r_height  <= i_cfg_data[12:0];
                    REG_RMASK:  r_mask[0] <= i_cfg_data;
                    REG_GMASK:  r_mask[1] <= i_cfg_data;
                    REG_BMASK:  r_mask[2] <= i_cfg_data;
                    REG_AMASK:  r_mask[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign pal_wr_ok   = {1'b0, i_palette_index} < 9'(PALETTE_DEPTH);
    assign pi_in_range = {1'b0, pi} < 9'(PALETTE_DEPTH);

    bpu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pal_wr && pal_wr_ok),
        .i_waddr (i_palette_index[ADDR_W-1:0]),
        .i_wdata (i_palette_color),
        .i_re    (i_cmd.pal_rd),
        .i_raddr (pi[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sh <= i_data_byte;
            r_y  <= h_eff - ROW_W'(1) - row_w;
        end else if (i_cmd.pix_adv) begin
            r_sh <= sh_next;
        end
        if (i_cmd.pal_rd) begin
            r_rd_ok <= pi_in_range && r_pal_vld[pi[ADDR_W-1:0]];
        end
        // restoring divide of (field*255) by the unshifted mask, one quotient bit a cycle
        for (int c = 0; c < 4; c++) begin
            logic [39:0] num;
            logic [32:0] trial;
            logic        ge;
            num   = {acc_or & r_mask[c], 8'd0} - {8'd0, acc_or & r_mask[c]};
            trial = {r_rem[c], r_q[c][7]};
            ge    = trial >= {1'b0, r_mask[c]};
            if (i_cmd.div_load) begin
                r_rem[c] <= num[39:8];
                r_q[c]   <= num[7:0];
            end else if (i_cmd.div_step) begin
                r_rem[c] <= ge ? 32'(trial - {1'b0, r_mask[c]}) : trial[31:0];
                r_q[c]   <= {r_q[c][6:0], ge};
            end
        end
        if (i_cmd.rgb_load) begin
            r_red   <= acc_or[23:16];
            r_green <= acc_or[15:8];
            r_blue  <= acc_or[7:0];
            r_alpha <= FULL_CHAN;
            r_x     <= r_col;
            r_last  <= 1'b1;
        end else if (i_cmd.bf_load) begin
            r_red   <= (r_mask[0] == '0) ? 8'd0 : r_q[0];
            r_green <= (r_mask[1] == '0) ? 8'd0 : r_q[1];
            r_blue  <= (r_mask[2] == '0) ? 8'd0 : r_q[2];
            r_alpha <= (r_mask[3] == '0) ? FULL_CHAN : r_q[3];
            r_x     <= r_col;
            r_last  <= 1'b1;
        end else if (i_cmd.pal_load) begin
            r_red   <= r_rd_ok ? ram_rdata[23:16] : 8'd0;
            r_green <= r_rd_ok ? ram_rdata[15:8] : 8'd0;
            r_blue  <= r_rd_ok ? ram_rdata[7:0] : 8'd0;
            r_alpha <= FULL_CHAN;
            r_x     <= r_col;
            r_last  <= (r_j == per_m1) || ((r_col + COL_W'(1)) >= w_eff);
        end
    end

    logic [31:0] x_ext, y_ext;
    assign x_ext     = 32'(r_x);
    assign y_ext     = 32'(r_y);
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_alpha   = r_alpha;
    assign o_pixel_x = x_ext[11:0];
    assign o_pixel_y = y_ext[11:0];
    assign o_last    = r_last;

    ap_bir_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin && (PAD_W'(r_bir + BIR_W'(1)) >= pad) |=> (r_bir == '0) && (r_col == '0))
        else $error("row end did not clear position");
    ap_take_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |=> (r_row < h_eff) || $past(i_cfg_we))
        else $error("row count out of range after byte");
endmodule

// ----- design/bpu_ctrl.sv -----
module bpu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    input  logic             i_out_ready,
    input  bpu_pkg::t_status i_status,
    output bpu_pkg::t_cmd    o_cmd
);
    import bpu_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRD    = 3'd1;
    localparam logic [2:0] S_PLOAD  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_BFLOAD = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       acc, take, out_xfer;

    assign acc      = (r_state == S_IDLE) && i_in_valid;
    assign take     = acc && (i_in_op == OP_PIXEL) && i_status.bpp_ok;
    assign out_xfer = (r_state == S_OUT) && i_out_ready;

    always_comb begin
        o_cmd.in_ready  = r_state == S_IDLE;
        o_cmd.pal_wr    = acc && (i_in_op == OP_PALETTE);
        o_cmd.take      = take;
        o_cmd.fin       = (take && ((i_status.pal_mode && !i_status.col_lt_w)
                                 || (!i_status.pal_mode && !i_status.pix_emit)))
                       || (out_xfer && i_status.out_last);
        o_cmd.div_load  = take && i_status.bf_mode && i_status.pix_emit;
        o_cmd.rgb_load  = take && !i_status.pal_mode && !i_status.bf_mode
                       && i_status.pix_emit;
        o_cmd.pal_rd    = r_state == S_PRD;
        o_cmd.pal_load  = r_state == S_PLOAD;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.bf_load   = r_state == S_BFLOAD;
        o_cmd.pix_adv   = out_xfer;
        o_cmd.out_valid = r_state == S_OUT;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = 3'd0;
                if (take) begin
                    if (i_status.pal_mode) begin
                        if (i_status.col_lt_w) begin
                            n_state = S_PRD;
                        end
                    end else if (i_status.pix_emit) begin
                        n_state = i_status.bf_mode ? S_DIV : S_OUT;
                    end
                end
            end
            S_PRD:    n_state = S_PLOAD;
            S_PLOAD:  n_state = S_OUT;
            S_DIV: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = S_BFLOAD;
                end
            end
            S_BFLOAD: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.out_last ? S_IDLE : S_PRD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    ap_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_valid |-> !o_cmd.in_ready)
        else $error("input ready while a pixel is pending");
    ap_pal_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRD) |=> (r_state == S_PLOAD))
        else $error("palette read not followed by load");
    ap_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BFLOAD) |-> ($past(r_state) == S_DIV) && ($past(r_cnt) == 3'd7))
        else $error("divide ended early");
endmodule

// ----- design/bmp_pixel_unpack_to_rgba_top.sv -----
// Output: a 24 bpp pixel is shown in the cycle after its last byte transfers; a 16/32
//   bpp pixel passes the 8-step shared-rate divider per channel, then the load register.
// Flow: a byte that yields no pixel leaves the sequencer idle, ready for the next byte;
//   each palette pixel passes the palette RAM registered read, its load and output wait.
// Reset: synchronous, active low; registers return to defaults, position clears,
//   palette valid bits clear so every entry reads black until written.
module bmp_pixel_unpack_to_rgba_top #(
    parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bpu_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpu_in_if.sink      i_in,
    bpu_cfg_if.sink     i_cfg,
    bpu_out_if.source   o_out
);
    import bpu_pkg::*;

    t_cmd    cmd;
    t_status status;

    // configuration writes always transfer; the user must send them only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = cmd.in_ready;
    assign o_out.valid = cmd.out_valid;

    // sequencer: one byte at a time, one pixel of it at a time
    bpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // position tracking, palette, bitfield divider and output register
    bpu_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_data_byte     (i_in.data_byte),
        .i_palette_index (i_in.palette_index),
        .i_palette_color (i_in.palette_color),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_red           (o_out.red),
        .o_green         (o_out.green),
        .o_blue          (o_out.blue),
        .o_alpha         (o_out.alpha),
        .o_pixel_x       (o_out.pixel_x),
        .o_pixel_y       (o_out.pixel_y),
        .o_last          (o_out.last)
    );
endmodule

// ----- verif/bpu_tb_if.sv -----
`timescale 1ns / 100ps

// Testbench-side bundles of the pending input transfer and of an output pixel; kept as struct types.
package bpu_tb_types;
    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        last;
    } t_pixel;
endpackage

// ----- verif/bmp_pixel_unpack_to_rgba_top_test.sv -----
`timescale 1ns / 100ps

module bmp_pixel_unpack_to_rgba_top_test;
    import bpu_pkg::*;
    import bpu_tb_types::*;

    localparam int LIMIT_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpu_in_if  in_ch();
    bpu_cfg_if cfg_ch();
    bpu_out_if out_ch();

    bmp_pixel_unpack_to_rgba_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: a copy of the block's registers and position.
    logic [5:0]  bpp_reg;
    logic [12:0] width_reg, height_reg;
    logic [31:0] rmask_reg, gmask_reg, bmask_reg, amask_reg;
    logic [23:0] palette_mem [256];
    logic [31:0] pix_acc;
    logic [1:0]  acc_bytes;
    int unsigned col_pos, row_pos, row_byte_pos;

    t_in_item pending_items[$];
    t_pixel   expected_pixels[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  quiet_mode = 1'b0;   // both sides never idle while set
    bit  sender_hold = 1'b0;
    bit  in_fired = 1'b0;     // offered transfer was taken at the last rising edge

    function automatic void add_expected(t_pixel px);
        expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    function automatic void add_pending(t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [7:0] scale_field(logic [31:0] pix, logic [31:0] mask,
                                               logic [7:0] if_zero);
        int unsigned sh;
        logic [31:0] m;
        logic [63:0] f;
        if (mask == 0) return if_zero;
        sh = 0;
        while (mask[sh] == 1'b0) sh++;
        m = mask >> sh;
        f = (pix & mask) >> sh;
        return 8'((f * 64'd255) / m);
    endfunction

    function automatic void clear_position();
        pix_acc = 0; acc_bytes = 0; col_pos = 0; row_pos = 0; row_byte_pos = 0;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_BPP:    bpp_reg = val[5:0];
            REG_WIDTH:  width_reg = val[12:0];
            REG_HEIGHT: height_reg = val[12:0];
            REG_RMASK:  rmask_reg = val;
            REG_GMASK:  gmask_reg = val;
            REG_BMASK:  bmask_reg = val;
            REG_AMASK:  amask_reg = val;
            default: ;
        endcase
    endfunction

    // Work out the pixels one accepted input transfer produces.
    function automatic void unpack_byte(t_in_item it);
        int unsigned w, h, y, row_bytes, padded, per, first_idx;
        logic [7:0] pi;
        logic [23:0] c;
        logic [31:0] p;
        t_pixel px;
        bit got;
        if (it.op == OP_PALETTE) begin
            palette_mem[it.palette_index] = it.palette_color;
            return;
        end
        if (!(bpp_reg inside {6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32})) return;
        w = (width_reg == 0) ? 1 : (width_reg > 4096 ? 4096 : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
        if (row_pos >= h) row_pos = 0;
        y = h - 1 - row_pos;
        row_bytes = (bpp_reg <= 8) ? (w * bpp_reg + 7) / 8 : w * (bpp_reg / 8);
        padded = (row_bytes + 3) & ~32'd3;
        first_idx = expected_pixels.size();
        got = 1'b0;
        if (bpp_reg <= 8) begin
            per = 8 / bpp_reg;
            for (int j = 0; j < per && col_pos < w; j++) begin
                pi = 8'((it.data_byte >> (8 - bpp_reg * (j + 1)))
                        & ((9'd1 << bpp_reg) - 1));
                c = palette_mem[pi];
                px = '{c[23:16], c[15:8], c[7:0], FULL_CHAN, 12'(col_pos), 12'(y), 1'b0};
                add_expected(px);
                got = 1'b1;
                col_pos++;
            end
        end else begin
            pix_acc |= 32'(it.data_byte) << (8 * acc_bytes);
            acc_bytes = acc_bytes + 2'd1;
            if (acc_bytes >= bpp_reg / 8 || acc_bytes == 0) begin
                p = pix_acc;
                if (col_pos < w) begin
                    if (bpp_reg == 24)
                        px = '{p[23:16], p[15:8], p[7:0], FULL_CHAN,
                               12'(col_pos), 12'(y), 1'b0};
                    else
                        px = '{scale_field(p, rmask_reg, 8'd0),
                               scale_field(p, gmask_reg, 8'd0),
                               scale_field(p, bmask_reg, 8'd0),
                               scale_field(p, amask_reg, FULL_CHAN),
                               12'(col_pos), 12'(y), 1'b0};
                    add_expected(px);
                    got = 1'b1;
                    col_pos++;
                end
                pix_acc = 0; acc_bytes = 0;
            end
        end
        row_byte_pos++;
        if (row_byte_pos >= padded) begin
            row_byte_pos = 0; col_pos = 0; acc_bytes = 0; pix_acc = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        if (got) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    // Driver: present pending transfers at the falling edge, idle at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fired) begin
            // hold the offered transfer
        end else if (pending_items.size() > 0 && !sender_hold &&
                     (quiet_mode || $urandom_range(99) >= 18)) begin
            in_ch.valid <= 1'b1;
            {in_ch.op, in_ch.data_byte, in_ch.palette_index, in_ch.palette_color}
                <= pending_items.pop_front();
        end else begin
            in_ch.valid <= 1'b0;
        end
        out_ch.ready <= quiet_mode || ($urandom_range(99) >= 18);
    end

    // Predict on each accepted input transfer.
    always @(posedge i_clk) begin
        in_fired <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            unpack_byte({in_ch.op, in_ch.data_byte, in_ch.palette_index,
                         in_ch.palette_color});
    end

    // Monitor: compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel got, exp_px;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                    out_ch.pixel_x, out_ch.pixel_y, out_ch.last};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %h", got);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (got !== exp_px) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("pixel mismatch: exp rgba %h %h %h %h x %0d y %0d l %b",
                                 exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                                 exp_px.pixel_x, exp_px.pixel_y, exp_px.last);
                        $display("                got rgba %h %h %h %h x %0d y %0d l %b",
                                 got.red, got.green, got.blue, got.alpha,
                                 got.pixel_x, got.pixel_y, got.last);
                    end
                end
            end
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("bmp_pixel_unpack_to_rgba_top_test NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        // extra settling time before the next register writes
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        apply_register(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_byte(logic [7:0] b);
        t_in_item it;
        it = '{OP_PIXEL, b, 8'($urandom), 24'($urandom)};
        add_pending(it);
    endtask

    task automatic queue_palette(logic [7:0] idx, logic [23:0] col);
        t_in_item it;
        it = '{OP_PALETTE, 8'($urandom), idx, col};
        add_pending(it);
    endtask

    // Queue n bytes of random content at the current setting.
    task automatic queue_image_bytes(int n);
        repeat (n) queue_byte(8'($urandom));
    endtask

    task automatic set_format(int bpp, int w, int h);
        write_register(REG_BPP, bpp);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
    endtask

    initial begin
        int unsigned rb;
        in_ch.valid = 1'b0; in_ch.op = OP_PIXEL; in_ch.data_byte = 0;
        in_ch.palette_index = 0; in_ch.palette_color = 0;
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_BPP; cfg_ch.data = 0;
        out_ch.ready = 1'b0;
        bpp_reg = 24; width_reg = 1; height_reg = 1;
        rmask_reg = 0; gmask_reg = 0; bmask_reg = 0; amask_reg = 0;
        foreach (palette_mem[i]) palette_mem[i] = 24'h0;
        clear_position();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset format (24 bpp, 1x1), extremes of byte values.
        queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'hA5); queue_byte(8'h5A);
        // unwritten palette entries read black at 8 bpp
        wait_drained();
        set_format(8, 3, 2);
        queue_palette(8'hFF, 24'hFFFFFF); queue_palette(8'h00, 24'h123456);
        queue_palette(8'h80, 24'hABCDEF);
        queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'h80); queue_byte(8'h7F);
        queue_byte(8'h11); queue_byte(8'h22); queue_byte(8'h33); queue_byte(8'h44);
        wait_drained();
        // 1 bpp, width 9: partial last byte, MSB-first
        set_format(1, 9, 1);
        queue_palette(8'h01, 24'h00FF00);
        queue_byte(8'hA5); queue_byte(8'h80); queue_byte(8'h00); queue_byte(8'h00);
        wait_drained();
        // invalid depth: bytes ignored
        write_register(REG_BPP, 3);
        queue_byte(8'h12); queue_byte(8'h34);
        wait_drained();
        // 32 bpp with full, zero and sparse masks
        write_register(REG_RMASK, 32'hFFFFFFFF);
        write_register(REG_GMASK, 32'h0);
        write_register(REG_BMASK, 32'h0000_0F00);
        write_register(REG_AMASK, 32'h0);
        set_format(32, 1, 1);
        queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
        queue_byte(8'h01); queue_byte(8'h0A); queue_byte(8'h00); queue_byte(8'h80);
        wait_drained();
        // width and height zero, then above the maximum
        set_format(24, 0, 0);
        queue_image_bytes(8);
        wait_drained();
        set_format(2, 8191, 8191);
        queue_image_bytes(6);
        wait_drained();
        // mid-image register change: position kept
        set_format(4, 3, 3);
        queue_image_bytes(3);
        wait_drained();
        write_register(REG_WIDTH, 1);
        queue_image_bytes(6);
        wait_drained();

        // Random phases: fill palette, then whole images per format.
        for (int i = 0; i < 24; i++) queue_palette(8'($urandom), 24'($urandom));
        for (int ph = 0; ph < 10; ph++) begin
            int bpps[7];
            int b, w, h;
            bpps = '{1, 2, 4, 8, 16, 24, 32};
            wait_drained();
            if (ph == 4) begin
                // sender waits here with nothing outstanding, no idling
                quiet_mode = 1'b1;
            end else begin
                quiet_mode = 1'b0;
            end
            b = bpps[$urandom_range(6)];
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 3);
            set_format(b, w, h);
            if (b == 16 || b == 32) begin
                write_register(REG_RMASK, (b == 16) ? 32'h7C00 : 32'($urandom));
                write_register(REG_GMASK, (b == 16) ? 32'h03E0 : 32'h0000_FF00);
                write_register(REG_BMASK, (b == 16) ? 32'h001F : 32'h0000_00FF);
                write_register(REG_AMASK, ($urandom_range(1)) ? 32'h8000_0000 : 32'h0);
            end
            rb = (b <= 8) ? (w * b + 7) / 8 : w * (b / 8);
            rb = (rb + 3) & ~32'd3;
            queue_image_bytes(rb * h);
            if ($urandom_range(3) == 0) queue_palette(8'($urandom), 24'($urandom));
        end
        quiet_mode = 1'b0;
        // pause the sender once until everything is back
        sender_hold = 1'b1;
        queue_image_bytes(8);
        while (expected_pixels.size() > 0) @(posedge i_clk);
        sender_hold = 1'b0;
        wait_drained();

        if (mismatches == 0) begin
            $display("bmp_pixel_unpack_to_rgba_top_test OK");
        end else begin
            $display("bmp_pixel_unpack_to_rgba_top_test NOT OK");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/bpu_pkg.sv
design/bpu_in_if.sv
design/bpu_out_if.sv
design/bpu_cfg_if.sv
design/bpu_ram.sv
design/bpu_datapath.sv
design/bpu_ctrl.sv
design/bmp_pixel_unpack_to_rgba_top.sv
verif/bpu_tb_if.sv
verif/bmp_pixel_unpack_to_rgba_top_test.sv
